// ===== design/morph_pkg.sv =====
// ----------------------------------------------------------------------------
// morph_pkg : shared types and constants for the 3x3 morphology block
// Pixel, window column and column-reduction types, register indexes and
// fixed field widths used by the top level and the window cells.
// ----------------------------------------------------------------------------
`default_nettype none

package morph_pkg;

    // fixed field widths
    localparam int PIX_W      = 8;
    localparam int WIDTH_W    = 11;
    localparam int HEIGHT_W   = 12;
    localparam int ROW_W      = 13;    // holds the last bordered row, height + 1
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 12;

    // frame geometry
    localparam int BORDER        = 1;
    localparam int WIN           = 2 * BORDER + 1;
    localparam int DEF_MAX_WIDTH = 1024;
    localparam int RST_WIDTH     = 320;
    localparam int RST_HEIGHT    = 240;

    // configuration register indexes
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_MODE   = 2'd0,
        CFG_WIDTH  = 2'd1,
        CFG_HEIGHT = 2'd2
    } t_cfg_idx;

    // operation select
    localparam logic MODE_ERODE  = 1'b0;
    localparam logic MODE_DILATE = 1'b1;

    typedef logic [PIX_W-1:0] t_pix;

    // one window column, top to bottom
    typedef struct packed {
        t_pix above2;
        t_pix above1;
        t_pix cur;
    } t_col;

    // line store entry: the two previous rows at one column
    typedef struct packed {
        t_pix older;
        t_pix newer;
    } t_line;

    // column reduced both ways, so a mode change never needs a refill
    typedef struct packed {
        t_pix all_and;
        t_pix any_or;
    } t_red;

    function automatic t_red f_col_red(input t_col col);
        t_red red;
        red.all_and = col.above2 & col.above1 & col.cur;
        red.any_or  = col.above2 | col.above1 | col.cur;
        return red;
    endfunction

endpackage

`default_nettype wire

// ===== design/morph_cell.sv =====
// ----------------------------------------------------------------------------
// morph_cell : one column cell of the 3x3 window chain
// Holds the AND and OR reduction of one window column and takes the value
// of its newer neighbor on every shift.
// ----------------------------------------------------------------------------
`default_nettype none

module morph_cell
    import morph_pkg::*;
(
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  wire logic i_shift,
    input  wire t_red i_red,
    output t_red      o_red
);

    t_red r_red;
    t_red n_red;

    // load from the newer neighbor on a shift
    always_comb begin
        n_red = r_red;
        if (i_shift) begin
            n_red = i_red;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_red <= '0;
        end else begin
            r_red <= n_red;
        end
    end

    assign o_red = r_red;

endmodule

`default_nettype wire

// ===== design/morphology_3x3_erode_dilate.sv =====
// ----------------------------------------------------------------------------
// morphology_3x3_erode_dilate : 3x3 binary erosion / dilation on a stream
// Takes a bordered frame in raster order and emits one AND (erode) or OR
// (dilate) of the 3x3 neighborhood for every interior position.
// ----------------------------------------------------------------------------
// Usage
//   Input channel (i_valid / o_ready): one bordered pixel per transfer, with
//   i_frame_start on the first pixel of a frame, which clears the counters.
//   Output channel (o_valid / i_ready): one result per interior position;
//   border positions give none. o_frame_last marks the frame's last result.
//   Config channel (i_cfg_valid / o_cfg_ready, always ready): index 0 mode,
//   1 image width, 2 image height. Write only while the block is idle.
//   Throughput: one pixel per cycle while the output is not stalled. The line
//   store is one memory with a read in the accept cycle and the write back
//   as the pixel leaves the pixel stage, with a bypass for a repeated
//   column address. Path: an accepted pixel is registered in the pixel
//   stage, and its result then in the output register.
//   Stall: the output register holds while i_ready is low; the pixel stage
//   behind it keeps one more pixel, then o_ready drops.
//   Reset: counters, window and registers return to their defaults
//   (erode, 320 x 240); the line store is not cleared and needs no sweep.
// ----------------------------------------------------------------------------
`default_nettype none

module morphology_3x3_erode_dilate
    import morph_pkg::*;
#(
    parameter int MAX_WIDTH = DEF_MAX_WIDTH
) (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    // pixel input
    input  wire logic                  i_valid,
    output logic                       o_ready,
    input  wire logic [PIX_W-1:0]      i_pixel,
    input  wire logic                  i_frame_start,
    // result output
    output logic                       o_valid,
    input  wire logic                  i_ready,
    output logic [PIX_W-1:0]           o_result_pixel,
    output logic                       o_frame_last,
    // configuration writes
    input  wire logic                  i_cfg_valid,
    output logic                       o_cfg_ready,
    input  wire logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  wire logic [CFG_DATA_W-1:0] i_cfg_data
);

    localparam int LINE_LEN = MAX_WIDTH + 2 * BORDER;
    localparam int COL_W    = $clog2(LINE_LEN);
    localparam int CMP_W    = (COL_W > WIDTH_W) ? COL_W : WIDTH_W;

    // configuration registers
    logic                r_mode;
    logic [WIDTH_W-1:0]  r_width;
    logic [HEIGHT_W-1:0] r_height;

    // position counters
    logic [COL_W-1:0] r_col, n_col;
    logic [ROW_W-1:0] r_row, n_row;

    // pixel stage
    logic             r_s1_valid;
    t_pix             r_s1_pix;
    logic [COL_W-1:0] r_s1_col;
    logic             r_s1_res;
    logic             r_s1_last;
    t_line            r_rd;

    // output register
    logic r_out_valid;
    t_pix r_out_pix;
    logic r_out_last;

    // line store
    t_line r_mem [LINE_LEN];

    logic [CMP_W-1:0]    w_width_ext;
    logic [CMP_W-1:0]    w_eff_width;
    logic [HEIGHT_W-1:0] w_eff_height;
    logic [COL_W-1:0]    w_last_col;
    logic [ROW_W-1:0]    w_last_row;
    logic [COL_W-1:0]    w_col;
    logic [ROW_W-1:0]    w_row;
    logic                w_has_res;
    logic                w_is_last;
    logic                w_in_acc;
    logic                w_s1_adv;
    t_line               w_wdata;
    t_col                w_new_col;
    t_red                w_chain [WIN];
    t_pix                w_result;

    // config port never stalls
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode   <= MODE_ERODE;
            r_width  <= WIDTH_W'(RST_WIDTH);
            r_height <= HEIGHT_W'(RST_HEIGHT);
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                CFG_MODE:   r_mode   <= i_cfg_data[0];
                CFG_WIDTH:  r_width  <= i_cfg_data[WIDTH_W-1:0];
                CFG_HEIGHT: r_height <= i_cfg_data[HEIGHT_W-1:0];
                default: begin
                end
            endcase
        end
    end

    // effective frame size and last bordered column / row
    assign w_width_ext = CMP_W'(r_width);

    always_comb begin
        priority if (r_width == '0) begin
            w_eff_width = CMP_W'(1);
        end else if (w_width_ext > CMP_W'(MAX_WIDTH)) begin
            w_eff_width = CMP_W'(MAX_WIDTH);
        end else begin
            w_eff_width = w_width_ext;
        end
    end

    assign w_eff_height = (r_height == '0) ? HEIGHT_W'(1) : r_height;
    assign w_last_col   = COL_W'(w_eff_width + CMP_W'(2 * BORDER - 1));
    assign w_last_row   = ROW_W'(w_eff_height) + ROW_W'(2 * BORDER - 1);

    // handshake
    assign w_s1_adv = r_s1_valid && (!r_s1_res || !r_out_valid || i_ready);
    assign o_ready  = !r_s1_valid || w_s1_adv;
    assign w_in_acc = i_valid && o_ready;

    // position of the incoming pixel
    assign w_col = i_frame_start ? '0 : r_col;
    assign w_row = i_frame_start ? '0 : r_row;

    assign w_has_res = (w_row >= ROW_W'(2 * BORDER)) && (w_row <= w_last_row) &&
                       (w_col >= COL_W'(2 * BORDER)) && (w_col <= w_last_col);
    assign w_is_last = (w_row == w_last_row) && (w_col == w_last_col);

    // counter advance, row wraps at the last bordered row
    always_comb begin
        n_col = r_col;
        n_row = r_row;
        if (w_in_acc) begin
            if (w_col >= w_last_col) begin
                n_col = '0;
                n_row = (w_row >= w_last_row) ? '0 : w_row + ROW_W'(1);
            end else begin
                n_col = w_col + COL_W'(1);
                n_row = w_row;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col <= '0;
            r_row <= '0;
        end else begin
            r_col <= n_col;
            r_row <= n_row;
        end
    end

    // line store write back: shift the column down by one row
    assign w_wdata.older = r_rd.newer;
    assign w_wdata.newer = r_s1_pix;

    always_ff @(posedge i_clk) begin
        if (w_s1_adv) begin
            r_mem[r_s1_col] <= w_wdata;
        end
    end

    // line store read, bypassing a write to the same column in this cycle
    always_ff @(posedge i_clk) begin
        if (w_in_acc) begin
            if (w_s1_adv && (r_s1_col == w_col)) begin
                r_rd <= w_wdata;
            end else begin
                r_rd <= r_mem[w_col];
            end
        end
    end

    // pixel stage control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (w_in_acc) begin
            r_s1_valid <= 1'b1;
        end else if (w_s1_adv) begin
            r_s1_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_in_acc) begin
            r_s1_pix  <= i_pixel;
            r_s1_col  <= w_col;
            r_s1_res  <= w_has_res;
            r_s1_last <= w_is_last;
        end
    end

    // newest window column enters the cell chain
    assign w_new_col.above2 = r_rd.older;
    assign w_new_col.above1 = r_rd.newer;
    assign w_new_col.cur    = r_s1_pix;
    assign w_chain[WIN-1]   = f_col_red(w_new_col);

    // cell k holds the column that cell k+1 held before the shift
    for (genvar k = 0; k < WIN - 1; k++) begin : g_cell
        morph_cell u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_shift (w_s1_adv),
            .i_red   (w_chain[k+1]),
            .o_red   (w_chain[k])
        );
    end

    // combine the column reductions of the shifted window
    always_comb begin
        t_pix acc_and;
        t_pix acc_or;
        acc_and = '1;
        acc_or  = '0;
        for (int k = 0; k < WIN; k++) begin
            acc_and = acc_and & w_chain[k].all_and;
            acc_or  = acc_or  | w_chain[k].any_or;
        end
        w_result = (r_mode == MODE_DILATE) ? acc_or : acc_and;
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_s1_adv && r_s1_res) begin
            r_out_valid <= 1'b1;
        end else if (i_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_s1_adv && r_s1_res) begin
            r_out_pix  <= w_result;
            r_out_last <= r_s1_last;
        end
    end

    assign o_valid        = r_out_valid;
    assign o_result_pixel = r_out_pix;
    assign o_frame_last   = r_out_last;

    // checks
    a_acc_loads_stage: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_in_acc |=> r_s1_valid)
        else $error("accepted pixel did not reach the pixel stage");

    a_last_has_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_s1_valid && r_s1_last) |-> r_s1_res)
        else $error("frame end marked on a border position");

    a_stall_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_s1_valid && !w_s1_adv) |-> (r_out_valid && !i_ready))
        else $error("pixel stage held without an output stall");

    a_col_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_col <= COL_W'(LINE_LEN - 1))
        else $error("column counter beyond the line store");

endmodule

`default_nettype wire
